>>> rtl/subcarrier_spatial_mapper_macros.svh
// Assertion macros used by the checker of the spatial mapper.
`ifndef SUBCARRIER_SPATIAL_MAPPER_MACROS_SVH
`define SUBCARRIER_SPATIAL_MAPPER_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SSM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, on the house clock and reset names.
`define SSM_ASSERT(lbl, prop, msg) \
  `SSM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/ssm_pkg.sv
// Types, constants and helpers for the subcarrier spatial mapper.
package ssm_pkg;

  // Default limits handed to the top level parameters
  localparam int DEF_MAX_SUBCARRIERS = 1024;
  localparam int DEF_MAX_ANTENNAS    = 4;
  localparam int DEF_MAX_STREAMS     = 2;

  // Output lanes and stream slots of the datapath (fixed by the port fields)
  localparam int NUM_ANT = 4;
  localparam int NUM_STR = 2;

  // Field widths
  localparam int SMP_W   = 16;
  localparam int OUT_W   = 18;
  localparam int PROD_W  = 32;
  localparam int SUM_W   = 34;
  localparam int SCIDX_W = 10;
  localparam int ANTIDX_W = 2;

  // Rounding to Q3.15: add half an LSB, then shift
  localparam int ROUND_BIAS  = 8192;
  localparam int ROUND_SHIFT = 14;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int STR_CNT_W   = 2;
  localparam int ANT_CNT_W   = 3;
  localparam int SC_CNT_W    = 11;
  localparam int SC_HARD_CAP = 1024;

  // Stream bus widths and input field offsets
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 144;
  localparam int SMP_LSB     = 0;
  localparam int CSC_LSB     = 64;
  localparam int CANT_LSB    = 74;
  localparam int CSTR_LSB    = 76;
  localparam int COEF_LSB    = 77;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STREAM_COUNT     = 2'd0,
    CFG_ANTENNA_COUNT    = 2'd1,
    CFG_SUBCARRIER_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_MAP  = 1'b0,
    OP_COEF = 1'b1
  } op_e;

  // Complex 16-bit value, real part in the low half
  typedef struct packed {
    logic signed [SMP_W-1:0] im;
    logic signed [SMP_W-1:0] re;
  } cplx_t;

  // Complex 18-bit output, real part in the low half
  typedef struct packed {
    logic signed [OUT_W-1:0] im;
    logic signed [OUT_W-1:0] re;
  } out_cplx_t;

  typedef cplx_t     [NUM_STR-1:0]              smp_vec_t;
  typedef cplx_t     [NUM_ANT-1:0][NUM_STR-1:0] coef_mat_t;
  typedef out_cplx_t [NUM_ANT-1:0]              out_vec_t;

  // Per-item control handed from the sequencer to the datapath
  typedef struct packed {
    logic               two_streams;
    logic [NUM_ANT-1:0] ant_en;
    logic               symbol_end;
  } map_ctrl_t;

  // Round half up by 2^14 and clamp to the 18-bit output range
  function automatic logic signed [OUT_W-1:0] sat_round(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] r;
    logic                    fits;
    r    = s + SUM_W'(ROUND_BIAS);
    r    = r >>> ROUND_SHIFT;
    fits = (&r[SUM_W-1:OUT_W-1]) | ~(|r[SUM_W-1:OUT_W-1]);
    if (fits) begin
      return r[OUT_W-1:0];
    end else if (r[SUM_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/ssm_coef_mem.sv
// Coefficient memory: one row per subcarrier holding every matrix entry.
module ssm_coef_mem import ssm_pkg::*; #(
  parameter int MAX_SUBCARRIERS = DEF_MAX_SUBCARRIERS,
  parameter int MAX_ANTENNAS    = DEF_MAX_ANTENNAS,
  parameter int MAX_STREAMS     = DEF_MAX_STREAMS,
  localparam int ROW_W = (MAX_SUBCARRIERS > 1) ? $clog2(MAX_SUBCARRIERS) : 1
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [SCIDX_W-1:0] wr_subcarrier_i,
  input  logic [ANTIDX_W-1:0] wr_antenna_i,
  input  logic               wr_stream_i,
  input  cplx_t              wr_data_i,
  input  logic               rd_en_i,
  input  logic [ROW_W-1:0]   rd_row_i,
  output coef_mat_t          rd_coef_o
);

  localparam int LANES  = MAX_ANTENNAS * MAX_STREAMS;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [LANES-1:0][2*SMP_W-1:0] mem_q [MAX_SUBCARRIERS];
  logic [LANES-1:0][2*SMP_W-1:0] rd_q;
  logic                          wr_ok;
  logic [ROW_W-1:0]              wr_row;
  logic [LANE_W-1:0]             wr_lane;

  // Writes outside the memory's parameter limits are dropped
  assign wr_ok = (int'(wr_subcarrier_i) < MAX_SUBCARRIERS) &&
                 (int'(wr_antenna_i) < MAX_ANTENNAS) &&
                 (int'(wr_stream_i) < MAX_STREAMS);
  assign wr_row  = ROW_W'(wr_subcarrier_i);
  assign wr_lane = LANE_W'(int'(wr_antenna_i) * MAX_STREAMS + int'(wr_stream_i));

  // Lane write, whole-row registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_ok) begin
      mem_q[wr_row][wr_lane] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_row_i];
    end
  end

  // Spread the row over the full 4x2 matrix; absent slots read zero
  for (genvar a = 0; a < NUM_ANT; a++) begin : g_ant
    for (genvar s = 0; s < NUM_STR; s++) begin : g_str
      if (a < MAX_ANTENNAS && s < MAX_STREAMS) begin : g_lane
        assign rd_coef_o[a][s] = rd_q[a*MAX_STREAMS + s];
      end else begin : g_none
        assign rd_coef_o[a][s] = '0;
      end
    end
  end

endmodule

>>> rtl/ssm_ctrl.sv
// Configuration registers and the subcarrier position sequencer.
module ssm_ctrl import ssm_pkg::*; #(
  parameter int MAX_SUBCARRIERS = DEF_MAX_SUBCARRIERS,
  parameter int MAX_ANTENNAS    = DEF_MAX_ANTENNAS,
  parameter int MAX_STREAMS     = DEF_MAX_STREAMS,
  localparam int ROW_W = (MAX_SUBCARRIERS > 1) ? $clog2(MAX_SUBCARRIERS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  map_acc_i,
  output logic [ROW_W-1:0]      row_o,
  output map_ctrl_t             ctrl_o
);

  localparam int SC_LIMIT = (MAX_SUBCARRIERS < SC_HARD_CAP) ? MAX_SUBCARRIERS : SC_HARD_CAP;
  localparam int CMP_W    = (ROW_W + 1 > SC_CNT_W) ? ROW_W + 1 : SC_CNT_W;

  logic [STR_CNT_W-1:0] str_cnt_q;
  logic [ANT_CNT_W-1:0] ant_cnt_q;
  logic [SC_CNT_W-1:0]  sc_cnt_q;
  logic [ROW_W-1:0]     pos_q, pos_d;
  logic [SC_CNT_W-1:0]  cnt_eff;
  logic [CMP_W-1:0]     pos_inc;
  logic                 last;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_cnt_q <= STR_CNT_W'(2);
      ant_cnt_q <= ANT_CNT_W'(2);
      sc_cnt_q  <= SC_CNT_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STREAM_COUNT:     str_cnt_q <= cfg_wdata_i[STR_CNT_W-1:0];
        CFG_ANTENNA_COUNT:    ant_cnt_q <= cfg_wdata_i[ANT_CNT_W-1:0];
        CFG_SUBCARRIER_COUNT: sc_cnt_q  <= cfg_wdata_i[SC_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective symbol length: zero acts as one, clamp to the limit
  always_comb begin
    if (sc_cnt_q == '0) begin
      cnt_eff = SC_CNT_W'(1);
    end else if (int'(sc_cnt_q) > SC_LIMIT) begin
      cnt_eff = SC_CNT_W'(SC_LIMIT);
    end else begin
      cnt_eff = sc_cnt_q;
    end
  end

  // Position advance and wrap
  assign pos_inc = CMP_W'(pos_q) + CMP_W'(1);
  assign last    = (pos_inc >= CMP_W'(cnt_eff));
  assign pos_d   = last ? '0 : pos_inc[ROW_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (map_acc_i) begin
      pos_q <= pos_d;
    end
  end

  // Per-item control: active streams, active antennas, end of symbol
  always_comb begin
    ctrl_o.two_streams = (str_cnt_q >= STR_CNT_W'(2)) && (MAX_STREAMS >= 2);
    for (int a = 0; a < NUM_ANT; a++) begin
      ctrl_o.ant_en[a] = (ant_cnt_q > ANT_CNT_W'(a)) && (a < MAX_ANTENNAS);
    end
    ctrl_o.symbol_end = last;
  end

  assign row_o = pos_q;

endmodule

>>> rtl/ssm_mac.sv
// Complex matrix-vector datapath: operand, product, sum and rounding stages.
module ssm_mac import ssm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  smp_vec_t  smp_i,
  input  map_ctrl_t ctrl_i,
  input  coef_mat_t coef_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_vec_t  out_data_o,
  output logic      out_last_o
);

  logic en1, en2, en3, en_out;
  logic v1_q, v2_q, v3_q, vo_q;

  smp_vec_t  smp1_q;
  map_ctrl_t ctl1_q;
  logic      last2_q, last3_q, lasto_q;

  logic signed [PROD_W-1:0] p_rr_q [NUM_ANT][NUM_STR];
  logic signed [PROD_W-1:0] p_ii_q [NUM_ANT][NUM_STR];
  logic signed [PROD_W-1:0] p_ri_q [NUM_ANT][NUM_STR];
  logic signed [PROD_W-1:0] p_ir_q [NUM_ANT][NUM_STR];
  logic signed [SUM_W-1:0]  sum_re_q [NUM_ANT];
  logic signed [SUM_W-1:0]  sum_im_q [NUM_ANT];
  coef_mat_t                coef_m;
  out_vec_t                 res_q;

  // Stage advance: a stage moves when empty or when its successor moves
  assign en_out     = ~vo_q | out_ready_i;
  assign en3        = ~v3_q | en_out;
  assign en2        = ~v2_q | en3;
  assign en1        = ~v1_q | en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)    v1_q <= in_valid_i;
      if (en2)    v2_q <= v1_q;
      if (en3)    v3_q <= v2_q;
      if (en_out) vo_q <= v3_q;
    end
  end

  // Zero the coefficients of unused antennas and streams
  always_comb begin
    for (int a = 0; a < NUM_ANT; a++) begin
      for (int s = 0; s < NUM_STR; s++) begin
        if (ctl1_q.ant_en[a] && (s == 0 || ctl1_q.two_streams)) begin
          coef_m[a][s] = coef_i[a][s];
        end else begin
          coef_m[a][s] = '0;
        end
      end
    end
  end

  // Operand stage (coefficients arrive registered from the memory)
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      smp1_q <= smp_i;
      ctl1_q <= ctrl_i;
    end
  end

  // Product stage: four real products per matrix entry
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      for (int a = 0; a < NUM_ANT; a++) begin
        for (int s = 0; s < NUM_STR; s++) begin
          p_rr_q[a][s] <= coef_m[a][s].re * smp1_q[s].re;
          p_ii_q[a][s] <= coef_m[a][s].im * smp1_q[s].im;
          p_ri_q[a][s] <= coef_m[a][s].re * smp1_q[s].im;
          p_ir_q[a][s] <= coef_m[a][s].im * smp1_q[s].re;
        end
      end
      last2_q <= ctl1_q.symbol_end;
    end
  end

  // Sum stage: exact Q5.29 accumulation over both streams
  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      for (int a = 0; a < NUM_ANT; a++) begin
        sum_re_q[a] <= SUM_W'(p_rr_q[a][0]) - SUM_W'(p_ii_q[a][0])
                     + SUM_W'(p_rr_q[a][1]) - SUM_W'(p_ii_q[a][1]);
        sum_im_q[a] <= SUM_W'(p_ri_q[a][0]) + SUM_W'(p_ir_q[a][0])
                     + SUM_W'(p_ri_q[a][1]) + SUM_W'(p_ir_q[a][1]);
      end
      last3_q <= last2_q;
    end
  end

  // Output register: round to Q3.15 and saturate
  always_ff @(posedge clk_i) begin
    if (en_out && v3_q) begin
      for (int a = 0; a < NUM_ANT; a++) begin
        res_q[a].re <= sat_round(sum_re_q[a]);
        res_q[a].im <= sat_round(sum_im_q[a]);
      end
      lasto_q <= last3_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = res_q;
  assign out_last_o  = lasto_q;

endmodule

>>> rtl/subcarrier_spatial_mapper.sv
// Top level of the per-subcarrier MIMO spatial mapper.
//
// Channel   Dir  Handshake                 Contents
// s_axis    in   s_axis_tvalid/tready      tuser: operation; tdata: samples, coef entry
// m_axis    out  m_axis_tvalid/tready      tdata: antenna 0..3 re/im; tlast: symbol end
// cfg       in   cfg_we_i (no wait)        cfg_idx_i register index, cfg_wdata_i value
//
// One input transaction per clock while s_axis_tready is high, mapping or coefficient
// write alike; coefficient writes give no result. A mapping result passes the memory
// read at the accepting edge, then the product, sum and round/saturate stages.
// The coefficient row of the current subcarrier is read at the accepting edge,
// so a write is visible to any later mapping transaction without forwarding.
// Reset clears the pipeline and position counter and loads the register defaults; the
// coefficient memory is not cleared. Output stalls hold the result and let the earlier
// stages fill before input backpressure is applied.
module subcarrier_spatial_mapper import ssm_pkg::*; #(
  parameter int MAX_SUBCARRIERS = DEF_MAX_SUBCARRIERS,
  parameter int MAX_ANTENNAS    = DEF_MAX_ANTENNAS,
  parameter int MAX_STREAMS     = DEF_MAX_STREAMS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // stream0_re, stream0_im, stream1_re, stream1_im, coef_subcarrier,
  // coef_antenna, coef_stream, coef_re, coef_im, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]             s_axis_tuser,   // operation
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // ant0_re, ant0_im, ant1_re, ant1_im, ant2_re, ant2_im, ant3_re, ant3_im
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,   // symbol_end
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int ROW_W = (MAX_SUBCARRIERS > 1) ? $clog2(MAX_SUBCARRIERS) : 1;

  logic       in_acc, map_acc, coef_acc;
  logic [ROW_W-1:0] row;
  map_ctrl_t  ctrl;
  coef_mat_t  coef;
  smp_vec_t   smp;
  cplx_t      wr_coef;
  out_vec_t   res;

  // Input transaction decode
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign map_acc  = in_acc & (op_e'(s_axis_tuser[0]) == OP_MAP);
  assign coef_acc = in_acc & (op_e'(s_axis_tuser[0]) == OP_COEF);
  assign smp      = s_axis_tdata[SMP_LSB +: NUM_STR*2*SMP_W];
  assign wr_coef  = s_axis_tdata[COEF_LSB +: 2*SMP_W];

  ssm_ctrl #(
    .MAX_SUBCARRIERS (MAX_SUBCARRIERS),
    .MAX_ANTENNAS    (MAX_ANTENNAS),
    .MAX_STREAMS     (MAX_STREAMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .map_acc_i   (map_acc),
    .row_o       (row),
    .ctrl_o      (ctrl)
  );

  ssm_coef_mem #(
    .MAX_SUBCARRIERS (MAX_SUBCARRIERS),
    .MAX_ANTENNAS    (MAX_ANTENNAS),
    .MAX_STREAMS     (MAX_STREAMS)
  ) u_mem (
    .clk_i           (clk_i),
    .wr_en_i         (coef_acc),
    .wr_subcarrier_i (s_axis_tdata[CSC_LSB +: SCIDX_W]),
    .wr_antenna_i    (s_axis_tdata[CANT_LSB +: ANTIDX_W]),
    .wr_stream_i     (s_axis_tdata[CSTR_LSB]),
    .wr_data_i       (wr_coef),
    .rd_en_i         (map_acc),
    .rd_row_i        (row),
    .rd_coef_o       (coef)
  );

  ssm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (map_acc),
    .in_ready_o  (s_axis_tready),
    .smp_i       (smp),
    .ctrl_i      (ctrl),
    .coef_i      (coef),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = res;

endmodule

>>> rtl/ssm_checker.sv
// Port-level checker for the spatial mapper, bound to the top level.
`include "subcarrier_spatial_mapper_macros.svh"

module ssm_checker import ssm_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_tready_i,
  input logic [OUT_TDATA_W-1:0] m_tdata_i,
  input logic                   m_tlast_i,
  input logic                   m_tvalid_i,
  input logic                   m_tready_i,
  input logic                   cfg_we_i,
  input logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic [ANT_CNT_W-1:0] ant_cnt_q;
  logic [SC_CNT_W-1:0]  sc_cnt_q;

  // Shadow copies of the registers that shape the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ant_cnt_q <= ANT_CNT_W'(2);
      sc_cnt_q  <= SC_CNT_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ANTENNA_COUNT:    ant_cnt_q <= cfg_wdata_i[ANT_CNT_W-1:0];
        CFG_SUBCARRIER_COUNT: sc_cnt_q  <= cfg_wdata_i[SC_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A stalled result holds its payload
  `SSM_ASSERT(a_out_hold, m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i), "output transaction changed while stalled")

  // With no result pending the input side is open
  `SSM_ASSERT(a_ready_when_empty, !m_tvalid_i |-> s_tready_i, "input blocked with empty output")

  // Antennas 2 and 3 are silent with two or fewer antennas in use
  `SSM_ASSERT(a_unused_ant_zero, m_tvalid_i && (ant_cnt_q <= ANT_CNT_W'(2)) |-> (m_tdata_i[OUT_TDATA_W-1:2*2*OUT_W] == '0), "unused antenna output not zero")

  // A one-subcarrier symbol ends on every transaction
  `SSM_ASSERT(a_single_sc_last, m_tvalid_i && (sc_cnt_q <= SC_CNT_W'(1)) |-> m_tlast_i, "symbol end missing for single-subcarrier symbol")

endmodule

bind subcarrier_spatial_mapper ssm_checker u_ssm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .s_tready_i  (s_axis_tready),
  .m_tdata_i   (m_axis_tdata),
  .m_tlast_i   (m_axis_tlast),
  .m_tvalid_i  (m_axis_tvalid),
  .m_tready_i  (m_axis_tready),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i)
);
